@@ src/murmur_hash1_stream_top_assert.svh @@
// Assertion macros used by the checker of the hash stream block.
`ifndef MURMUR_HASH1_STREAM_TOP_ASSERT_SVH
`define MURMUR_HASH1_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet while aresetn is low.
`define MH1S_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while aresetn is low.
`define MH1S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mh1s_pkg.sv @@
// Package with the shared constants and command type of the hash stream block.
`default_nettype none

package mh1s_pkg;

    // MurmurHash1 multiplier.
    localparam logic [31:0] HASH_MULT = 32'hc6a4a793;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One command for the back end: optional seed, optional word mix, optional finish.
    typedef struct packed {
        logic        seed;
        logic [31:0] length;
        logic        mix;
        logic [31:0] word;
        logic        fin;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/mh1s_front.sv @@
// Front end: packs message bytes into words and issues hash commands.
`default_nettype none

module mh1s_front (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              accept,
    input  wire              start_req,
    input  wire [31:0]       message_length,
    input  wire [7:0]        data_byte,
    input  wire              byte_valid,
    input  wire              last,
    output logic             push,
    output mh1s_pkg::cmd_t   cmd
);

    logic [31:0] wbuf_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] wbuf_next;
    logic [1:0]  cnt_next;

    logic [31:0] base_buf;
    logic [1:0]  base_cnt;
    logic [31:0] placed;
    logic        full;
    logic [31:0] after_buf;
    logic [1:0]  after_cnt;
    logic        tail;

    // Start discards the partial word, then the byte lands little-endian.
    always_comb begin
        base_buf = start_req ? 32'd0 : wbuf_reg;
        base_cnt = start_req ? 2'd0 : cnt_reg;
        placed   = base_buf;
        case (base_cnt)
            2'd0: placed[7:0]   = data_byte;
            2'd1: placed[15:8]  = data_byte;
            2'd2: placed[23:16] = data_byte;
            2'd3: placed[31:24] = data_byte;
            default: placed = base_buf;
        endcase
        full = byte_valid && (base_cnt == 2'd3);
        if (full) begin
            after_buf = 32'd0;
            after_cnt = 2'd0;
        end else if (byte_valid) begin
            after_buf = placed;
            after_cnt = base_cnt + 2'd1;
        end else begin
            after_buf = base_buf;
            after_cnt = base_cnt;
        end
        // A full word and a tail never come from the same item.
        tail       = last && (after_cnt != 2'd0);
        cmd.seed   = start_req;
        cmd.length = message_length;
        cmd.mix    = full || tail;
        cmd.word   = full ? placed : after_buf;
        cmd.fin    = last;
        push       = accept && (start_req || full || last);
        wbuf_next  = last ? 32'd0 : after_buf;
        cnt_next   = last ? 2'd0 : after_cnt;
    end

    // Partial word state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbuf_reg <= 32'd0;
            cnt_reg  <= 2'd0;
        end else if (accept) begin
            wbuf_reg <= wbuf_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mh1s_queue.sv @@
// Command queue that decouples the front end from the back end.
`default_nettype none

module mh1s_queue #(
    parameter int DEPTH = mh1s_pkg::QUEUE_DEPTH
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  mh1s_pkg::cmd_t  push_cmd,
    input  wire             pop,
    output mh1s_pkg::cmd_t  head_cmd,
    output logic            empty,
    output logic            full
);

    // DEPTH must be a power of two, at least two, so pointers wrap by themselves; not checked here.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    mh1s_pkg::cmd_t     mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(DEPTH));
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Storage, written only on push.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + CW'(1);
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/mh1s_back.sv @@
// Back end: runs seed, word mix and finalization on one shared multiplier.
`default_nettype none

module mh1s_back (
    input  wire             aclk,
    input  wire             aresetn,
    input  mh1s_pkg::cmd_t  head_cmd,
    input  wire             empty,
    output logic            pop,
    output logic            m_tvalid,
    input  wire             m_tready,
    output logic [31:0]     m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_CHECK,
        S_MIX_MUL,
        S_MIX_XS16,
        S_FIN_MUL1,
        S_FIN_XS10,
        S_FIN_MUL2,
        S_FIN_XS17,
        S_EMIT
    } state_t;

    state_t          state_reg;
    mh1s_pkg::cmd_t  cmd_reg;
    logic [31:0]     hash_reg;
    logic [31:0]     out_reg;
    logic            out_valid_reg;

    logic [31:0]     mul_in;
    logic [31:0]     product;

    // One multiplier, low 32 bits of the product only.
    assign mul_in  = (state_reg == S_SEED) ? cmd_reg.length : hash_reg;
    assign product = mul_in * mh1s_pkg::HASH_MULT;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Sequencer with the running hash and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hash_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            // The emit state refills the output register itself.
            if (out_valid_reg && m_tready && (state_reg != S_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!empty) begin
                        cmd_reg   <= head_cmd;
                        state_reg <= head_cmd.seed ? S_SEED : S_CHECK;
                    end
                end
                S_SEED: begin
                    hash_reg  <= product;
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (cmd_reg.mix) begin
                        hash_reg  <= hash_reg + cmd_reg.word;
                        state_reg <= S_MIX_MUL;
                    end else if (cmd_reg.fin) begin
                        state_reg <= S_FIN_MUL1;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MIX_MUL: begin
                    hash_reg  <= product;
                    state_reg <= S_MIX_XS16;
                end
                S_MIX_XS16: begin
                    hash_reg  <= hash_reg ^ (hash_reg >> 16);
                    state_reg <= cmd_reg.fin ? S_FIN_MUL1 : S_IDLE;
                end
                S_FIN_MUL1: begin
                    hash_reg  <= product;
                    state_reg <= S_FIN_XS10;
                end
                S_FIN_XS10: begin
                    hash_reg  <= hash_reg ^ (hash_reg >> 10);
                    state_reg <= S_FIN_MUL2;
                end
                S_FIN_MUL2: begin
                    hash_reg  <= product;
                    state_reg <= S_FIN_XS17;
                end
                S_FIN_XS17: begin
                    hash_reg  <= hash_reg ^ (hash_reg >> 17);
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // Hand the hash over once the output register is free.
                    if (!out_valid_reg || m_tready) begin
                        out_reg       <= hash_reg;
                        out_valid_reg <= 1'b1;
                        hash_reg      <= 32'd0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/murmur_hash1_stream_top.sv @@
// Top level of the streaming 32-bit MurmurHash1 (seed zero) block.
//
// Usage: a message enters one byte per item on the s_ channel. The first item carries
// s_tuser[0] (start) and the total length in s_tdata[31:0]; s_tuser[1] marks a valid
// byte in s_tdata[39:32]; s_tlast marks the final item. An empty message is a single
// item with start, last and no valid byte. The hash leaves as one item on the m_ channel.
// Throughput: the front end takes one byte per cycle while the command queue has room.
// Every fourth byte becomes a word command that the back end mixes on its single 32x32
// multiplier, so a steady stream sustains one byte per cycle; a start adds a seed step.
// After the last item, a free back end runs its sequence of seed, tail mix and the two
// finishing multiplies with xor-shifts, then raises m_tvalid with the hash.
// s_tready drops only when the command queue between front and back is full.
// When the receiver stalls, the hash waits in the output register; the back end
// keeps working on the next message until it must emit again.
// Reset (aresetn low, synchronous) empties the queue, clears the partial word and
// the running hash and drops m_tvalid. Items sent without a start continue from a
// zero hash.
`default_nettype none

module murmur_hash1_stream_top #(
    parameter int QUEUE_DEPTH = mh1s_pkg::QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // message_length [31:0], data_byte [39:32]
    input  wire  [1:0]  s_tuser,   // start_req [0], byte_valid [1]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata    // hash_value [31:0]
);

    logic            accept;
    logic            push;
    mh1s_pkg::cmd_t  push_cmd;
    mh1s_pkg::cmd_t  head_cmd;
    logic            q_empty;
    logic            q_full;
    logic            pop;

    // Accept items whenever the queue has room for a command.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    mh1s_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .start_req      (s_tuser[0]),
        .message_length (s_tdata[31:0]),
        .data_byte      (s_tdata[39:32]),
        .byte_valid     (s_tuser[1]),
        .last           (s_tlast),
        .push           (push),
        .cmd            (push_cmd)
    );

    mh1s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    mh1s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ src/mh1s_checker.sv @@
// Port-level checker for the hash stream block, bound to the top level.
`default_nettype none
`include "murmur_hash1_stream_top_assert.svh"

module mh1s_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata
);

    // Messages whose last item went in but whose hash has not been taken yet.
    logic [7:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 8'd0;
        end else begin
            case ({s_tvalid && s_tready && s_tlast, m_tvalid && m_tready})
                2'b10:   pend_reg <= pend_reg + 8'd1;
                2'b01:   pend_reg <= pend_reg - 8'd1;
                default: pend_reg <= pend_reg;
            endcase
        end
    end

    `MH1S_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped under stall")
    `MH1S_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed under stall")
    `MH1S_ASSERT_NOW(a_out_needs_last, m_tvalid, pend_reg != 8'd0, "hash without a finished message")
    `MH1S_ASSERT_NEXT(a_no_instant_hash, s_tvalid && s_tready && s_tlast && pend_reg == 8'd0, !m_tvalid, "hash came too early")

endmodule

bind murmur_hash1_stream_top mh1s_checker u_mh1s_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
